>>> sv/spimbs_pkg.sv
// ----------------------------------------------------------------------------
// spimbs_pkg
// Shared types, register indexes and bit helpers for the SPI byte shifter.
// ----------------------------------------------------------------------------
package spimbs_pkg;

  localparam int unsigned BITS_PER_WORD = 8;
  localparam int unsigned HALF_W        = 16;
  localparam int unsigned CNT_W         = 4;
  localparam int unsigned ADDR_W        = 4;
  localparam int unsigned DATA_W        = 32;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_CLOCK_IDLE_HIGH    = 2'd0;
  localparam logic [1:0] REG_SAMPLE_SECOND_EDGE = 2'd1;
  localparam logic [1:0] REG_LSB_FIRST          = 2'd2;
  localparam logic [1:0] REG_HALF_PERIOD        = 2'd3;

  typedef struct packed {
    logic              clock_idle_high;
    logic              sample_second_edge;
    logic              lsb_first;
    logic [HALF_W-1:0] half_period;
  } cfg_t;

  typedef struct packed {
    logic                     start_req;
    logic [BITS_PER_WORD-1:0] tx_byte;
    logic                     miso_level;
  } in_t;

  typedef struct packed {
    logic                     sck_level;
    logic                     mosi_level;
    logic                     busy_res;
    logic                     done_res;
    logic [BITS_PER_WORD-1:0] rx_byte;
  } out_t;

  typedef struct packed {
    logic                     busy;
    logic [CNT_W-1:0]         bit_count;
    logic                     half_phase;
    logic [HALF_W-1:0]        tick_count;
    logic [BITS_PER_WORD-1:0] tx_shift;
    logic [BITS_PER_WORD-1:0] rx_shift;
    logic                     sck;
    logic                     mosi;
  } state_t;

  // next mosi bit and the shifted transmit register, as {bit, shift}
  function automatic logic [BITS_PER_WORD:0] drive_bit(
    input logic [BITS_PER_WORD-1:0] shift,
    input logic                     lsb
  );
    logic [BITS_PER_WORD:0] r;
    if (lsb) begin
      r = {shift[0], 1'b0, shift[BITS_PER_WORD-1:1]};
    end else begin
      r = {shift[BITS_PER_WORD-1], shift[BITS_PER_WORD-2:0], 1'b0};
    end
    return r;
  endfunction

  // receive register after one sampled bit
  function automatic logic [BITS_PER_WORD-1:0] sample_bit(
    input logic [BITS_PER_WORD-1:0] shift,
    input logic                     miso,
    input logic                     lsb
  );
    logic [BITS_PER_WORD-1:0] r;
    if (lsb) begin
      r = {miso, shift[BITS_PER_WORD-1:1]};
    end else begin
      r = {shift[BITS_PER_WORD-2:0], miso};
    end
    return r;
  endfunction

endpackage

>>> sv/spimbs_regs.sv
// ----------------------------------------------------------------------------
// spimbs_regs
// APB-style configuration registers: idle level, sample edge, bit order and
// half period.
// ----------------------------------------------------------------------------
module spimbs_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spimbs_pkg::ADDR_W-1:0] paddr,
  input  logic [spimbs_pkg::DATA_W-1:0] pwdata,
  output logic [spimbs_pkg::DATA_W-1:0] prdata,
  output logic                          pready,
  output spimbs_pkg::cfg_t              cfg
);

  spimbs_pkg::cfg_t cfg_r;
  logic [1:0]       idx;
  logic             wr_en;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (idx)
        spimbs_pkg::REG_CLOCK_IDLE_HIGH:    cfg_r.clock_idle_high    <= pwdata[0];
        spimbs_pkg::REG_SAMPLE_SECOND_EDGE: cfg_r.sample_second_edge <= pwdata[0];
        spimbs_pkg::REG_LSB_FIRST:          cfg_r.lsb_first          <= pwdata[0];
        spimbs_pkg::REG_HALF_PERIOD:
          cfg_r.half_period <= pwdata[spimbs_pkg::HALF_W-1:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    unique case (idx)
      spimbs_pkg::REG_CLOCK_IDLE_HIGH:    prdata[0] = cfg_r.clock_idle_high;
      spimbs_pkg::REG_SAMPLE_SECOND_EDGE: prdata[0] = cfg_r.sample_second_edge;
      spimbs_pkg::REG_LSB_FIRST:          prdata[0] = cfg_r.lsb_first;
      spimbs_pkg::REG_HALF_PERIOD:
        prdata[spimbs_pkg::HALF_W-1:0] = cfg_r.half_period;
      default: prdata = '0;
    endcase
  end

endmodule

>>> sv/spimbs_step.sv
// ----------------------------------------------------------------------------
// spimbs_step
// Next-state logic for one bit-timer tick: start, edge timing, shift and
// sample, completion.
// ----------------------------------------------------------------------------
module spimbs_step (
  input  spimbs_pkg::cfg_t   cfg,
  input  spimbs_pkg::state_t st,
  input  spimbs_pkg::in_t    din,
  output spimbs_pkg::state_t nxt,
  output spimbs_pkg::out_t   res
);

  logic [spimbs_pkg::HALF_W-1:0]      h;
  logic [spimbs_pkg::HALF_W:0]        tick_inc;
  logic [spimbs_pkg::BITS_PER_WORD:0] drv;

  always_comb begin
    nxt      = st;
    res      = '0;
    drv      = '0;
    h        = (cfg.half_period == '0) ? spimbs_pkg::HALF_W'(1) : cfg.half_period;
    tick_inc = {1'b0, st.tick_count} + (spimbs_pkg::HALF_W + 1)'(1);

    if (!st.busy) begin
      // idle: sck at idle level, mosi low, wait for a start
      nxt.sck  = cfg.clock_idle_high;
      nxt.mosi = 1'b0;
      if (din.start_req) begin
        nxt.busy       = 1'b1;
        nxt.tx_shift   = din.tx_byte;
        nxt.rx_shift   = '0;
        nxt.bit_count  = '0;
        nxt.half_phase = 1'b0;
        nxt.tick_count = '0;
        if (!cfg.sample_second_edge) begin
          drv          = spimbs_pkg::drive_bit(din.tx_byte, cfg.lsb_first);
          nxt.mosi     = drv[spimbs_pkg::BITS_PER_WORD];
          nxt.tx_shift = drv[spimbs_pkg::BITS_PER_WORD-1:0];
        end
      end
    end else if (tick_inc >= {1'b0, h}) begin
      nxt.tick_count = '0;
      if (!st.half_phase) begin
        // leading edge
        nxt.sck        = ~cfg.clock_idle_high;
        nxt.half_phase = 1'b1;
        if (cfg.sample_second_edge) begin
          drv          = spimbs_pkg::drive_bit(st.tx_shift, cfg.lsb_first);
          nxt.mosi     = drv[spimbs_pkg::BITS_PER_WORD];
          nxt.tx_shift = drv[spimbs_pkg::BITS_PER_WORD-1:0];
        end else begin
          nxt.rx_shift = spimbs_pkg::sample_bit(st.rx_shift, din.miso_level,
                                                cfg.lsb_first);
        end
      end else begin
        // trailing edge, bit complete
        nxt.sck        = cfg.clock_idle_high;
        nxt.half_phase = 1'b0;
        if (cfg.sample_second_edge) begin
          nxt.rx_shift = spimbs_pkg::sample_bit(st.rx_shift, din.miso_level,
                                                cfg.lsb_first);
        end
        nxt.bit_count = st.bit_count + spimbs_pkg::CNT_W'(1);
        if (nxt.bit_count >= spimbs_pkg::CNT_W'(spimbs_pkg::BITS_PER_WORD)) begin
          nxt.busy      = 1'b0;
          nxt.bit_count = '0;
          nxt.mosi      = 1'b0;
          res.done_res  = 1'b1;
          res.rx_byte   = nxt.rx_shift;
        end else if (!cfg.sample_second_edge) begin
          drv          = spimbs_pkg::drive_bit(st.tx_shift, cfg.lsb_first);
          nxt.mosi     = drv[spimbs_pkg::BITS_PER_WORD];
          nxt.tx_shift = drv[spimbs_pkg::BITS_PER_WORD-1:0];
        end
      end
    end else begin
      nxt.tick_count = tick_inc[spimbs_pkg::HALF_W-1:0];
    end

    res.sck_level  = nxt.sck;
    res.mosi_level = nxt.mosi;
    res.busy_res   = nxt.busy;
  end

endmodule

>>> sv/spi_master_byte_shifter.sv
// ----------------------------------------------------------------------------
// spi_master_byte_shifter
// One-byte full-duplex SPI master, SCK polarity and phase selectable, one
// bit-timer tick per input transaction.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                  payload
//  in_      input      in_valid / in_ready        in_t  (start, tx byte, miso)
//  out_     output     out_valid / out_ready      out_t (sck, mosi, busy, done, rx)
//  cfg      input      APB psel/penable/pwrite    4 registers, 32-bit data
//
//  Each tick is one transaction; the state and result registers update on accept,
//  and a new tick is accepted every cycle while the result register drains.
//  out_valid rises in the cycle after accept; the output register holds
//  its transaction under out_ready low and then blocks in_ready.
//  Reset (rst_n low, synchronous) clears the configuration and all shifter state.
// ----------------------------------------------------------------------------
module spi_master_byte_shifter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  spimbs_pkg::in_t               in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output spimbs_pkg::out_t              out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [spimbs_pkg::ADDR_W-1:0] paddr,
  input  logic [spimbs_pkg::DATA_W-1:0] pwdata,
  output logic [spimbs_pkg::DATA_W-1:0] prdata,
  output logic                          pready
);

  spimbs_pkg::cfg_t   cfg;
  spimbs_pkg::state_t st_r;
  spimbs_pkg::state_t st_nxt;
  spimbs_pkg::out_t   res_nxt;
  spimbs_pkg::out_t   out_data_r;
  logic               out_valid_r;
  logic               in_fire;

  // configuration registers
  spimbs_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // per-tick next state
  spimbs_step u_step (
    .cfg (cfg),
    .st  (st_r),
    .din (in_data),
    .nxt (st_nxt),
    .res (res_nxt)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // shifter state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_data_r <= res_nxt;
    end
  end

  // checks
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.done_res |-> !out_data_r.busy_res)
    else $error("done reported while still busy");

  a_rx_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_data_r.done_res |-> out_data_r.rx_byte == '0)
    else $error("received byte shown without done");

  a_idle_count_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !st_r.busy |-> st_r.bit_count == '0 && st_r.half_phase == 1'b0)
    else $error("bit counter not cleared while idle");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.busy |-> st_r.bit_count < spimbs_pkg::CNT_W'(spimbs_pkg::BITS_PER_WORD))
    else $error("bit counter beyond word length");

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> $stable(st_r))
    else $error("shifter advanced while result stalled");

endmodule
